/* sv/wlp_pkg.sv */
// Package for the windowed latency percentile block.
// Holds sizes, state codes, the rank helper and the sample saturation helper; no dependencies.
`default_nettype none
package wlp_pkg;
    localparam int WINDOW_DEPTH = 128;
    localparam int SAMPLE_BITS  = 24;
    localparam int LAT_BITS     = 24;
    localparam int HELD_BITS    = 8;
    localparam int ADDR_BITS    = $clog2(WINDOW_DEPTH);
    localparam int CNT_BITS     = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_BITS     = SAMPLE_BITS + CNT_BITS;
    localparam int PROD_BITS    = CNT_BITS + 7;
    localparam int RECIP_SHIFT  = 24;
    localparam int RECIP_BITS   = 18;
    localparam logic [RECIP_BITS-1:0] RECIP_100 =
        RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'd99) / 64'd100);
    localparam logic [6:0] PCT_50 = 7'd50;
    localparam logic [6:0] PCT_95 = 7'd95;
    localparam logic [6:0] PCT_99 = 7'd99;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SUM  = 6'b000010,
        S_DIV  = 6'b000100,
        S_CAND = 6'b001000,
        S_SCAN = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    function automatic logic [CNT_BITS-1:0] rank_of(input logic [CNT_BITS-1:0] n,
                                                    input logic [6:0] pct);
        logic [PROD_BITS-1:0]            x;
        logic [PROD_BITS+RECIP_BITS-1:0] p;
        x = PROD_BITS'(n) * PROD_BITS'(pct);
        p = (PROD_BITS+RECIP_BITS)'(x) * (PROD_BITS+RECIP_BITS)'(RECIP_100);
        return CNT_BITS'(p >> RECIP_SHIFT);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] sat_sample(input logic [LAT_BITS-1:0] v);
        logic [LAT_BITS+SAMPLE_BITS-1:0] wide;
        logic [LAT_BITS+SAMPLE_BITS-1:0] smax;
        wide = (LAT_BITS+SAMPLE_BITS)'(v);
        smax = ((LAT_BITS+SAMPLE_BITS)'(1) << SAMPLE_BITS) - (LAT_BITS+SAMPLE_BITS)'(1);
        if (wide > smax)
            return SAMPLE_BITS'(smax);
        return SAMPLE_BITS'(wide);
    endfunction
endpackage
`default_nettype wire

/* sv/wlp_ram.sv */
// Single-port synchronous RAM with registered read.
// Generic; no package dependency.
`default_nettype none
module wlp_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 24
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output      logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        if (re)
            rdata <= mem[addr];
    end
endmodule
`default_nettype wire

/* sv/wlp_div.sv */
// Restoring divider, one quotient bit per cycle, for the window mean.
// Depends on wlp_pkg.
`default_nettype none
module wlp_div
    import wlp_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [SUM_BITS-1:0] dividend,
    input  wire logic [CNT_BITS-1:0] divisor,
    output      logic                done,
    output      logic [SUM_BITS-1:0] quotient
);
    localparam int STEP_BITS = $clog2(SUM_BITS);

    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic [STEP_BITS-1:0] step_reg, step_next;
    logic [SUM_BITS-1:0]  quo_reg, quo_next;
    logic [CNT_BITS-1:0]  rem_reg, rem_next;
    logic [CNT_BITS-1:0]  dsr_reg, dsr_next;
    logic [CNT_BITS:0]    trial;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[SUM_BITS-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            run_next  = 1'b1;
            step_next = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (run_reg)
        begin
            rem_next  = fits ? CNT_BITS'(trial - {1'b0, dsr_reg}) : CNT_BITS'(trial);
            quo_next  = {quo_reg[SUM_BITS-2:0], fits};
            step_next = step_reg + STEP_BITS'(1);
            if (step_reg == STEP_BITS'(SUM_BITS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

/* sv/windowed_latency_percentiles_top.sv */
// Top level of the windowed latency percentile block: sequencer over the sample RAM.
// Depends on wlp_pkg, wlp_ram and wlp_div.
// Record: one transfer per cycle, busy stays low, no result.
// Query: result strobe after the sum pass, the mean division and the rank scan, which
// reads every sample once per candidate through the single RAM port.
// Empty query: result strobe in the cycle after the transfer. Result strobe cannot stall.
// Reset clears write position, fill count and sequencer; RAM contents are not cleared.
`default_nettype none
module windowed_latency_percentiles_top
    import wlp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output      logic                 busy,
    input  wire logic                 op,
    input  wire logic [LAT_BITS-1:0]  latency_sample,
    output      logic                 done,
    output      logic [LAT_BITS-1:0]  median_latency,
    output      logic [LAT_BITS-1:0]  p95_latency,
    output      logic [LAT_BITS-1:0]  p99_latency,
    output      logic [LAT_BITS-1:0]  max_latency,
    output      logic [LAT_BITS-1:0]  mean_latency,
    output      logic [HELD_BITS-1:0] samples_held
);
    state_t                 state_reg, state_next;
    logic [ADDR_BITS-1:0]   wp_reg, wp_next;
    logic [CNT_BITS-1:0]    fill_reg, fill_next;
    logic [CNT_BITS-1:0]    n_reg, n_next;
    logic [CNT_BITS-1:0]    idx_reg, idx_next;
    logic [CNT_BITS-1:0]    rcv_reg, rcv_next;
    logic [CNT_BITS-1:0]    cidx_reg, cidx_next;
    logic                   vld_reg, vld_next;
    logic                   first_reg, first_next;
    logic                   done_reg, done_next;
    logic                   dstart_reg, dstart_next;
    logic [SUM_BITS-1:0]    sum_reg, sum_next;
    logic [SAMPLE_BITS-1:0] max_reg, max_next;
    logic [SAMPLE_BITS-1:0] cand_reg, cand_next;
    logic [CNT_BITS-1:0]    lt_reg, lt_next;
    logic [CNT_BITS-1:0]    eq_reg, eq_next;
    logic [CNT_BITS-1:0]    r50_reg, r50_next, r95_reg, r95_next, r99_reg, r99_next;
    logic [SAMPLE_BITS-1:0] v50_reg, v50_next, v95_reg, v95_next, v99_reg, v99_next;
    logic [SUM_BITS-1:0]    mean_reg, mean_next;
    logic [LAT_BITS-1:0]    o50_reg, o50_next, o95_reg, o95_next, o99_reg, o99_next;
    logic [LAT_BITS-1:0]    omax_reg, omax_next, omean_reg, omean_next;
    logic [HELD_BITS-1:0]   oheld_reg, oheld_next;

    logic                   accept;
    logic                   ram_we, ram_re;
    logic [ADDR_BITS-1:0]   ram_addr;
    logic [SAMPLE_BITS-1:0] ram_rdata;
    logic                   div_done;
    logic [SUM_BITS-1:0]    div_quo;
    logic [CNT_BITS-1:0]    lt_f, eq_f;
    logic [CNT_BITS:0]      hi_f;

    assign accept = start && !busy;
    assign busy   = state_reg != S_IDLE;

    wlp_ram #(.DEPTH(WINDOW_DEPTH), .WIDTH(SAMPLE_BITS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (sat_sample(latency_sample)),
        .rdata (ram_rdata)
    );

    wlp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dstart_reg),
        .dividend (sum_reg),
        .divisor  (n_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        lt_f = lt_reg + CNT_BITS'(ram_rdata < cand_reg);
        eq_f = eq_reg + CNT_BITS'(ram_rdata == cand_reg);
        hi_f = {1'b0, lt_f} + {1'b0, eq_f};
    end

    always_comb
    begin
        state_next  = state_reg;
        wp_next     = wp_reg;
        fill_next   = fill_reg;
        n_next      = n_reg;
        idx_next    = idx_reg;
        rcv_next    = rcv_reg;
        cidx_next   = cidx_reg;
        vld_next    = 1'b0;
        first_next  = 1'b0;
        done_next   = 1'b0;
        dstart_next = 1'b0;
        sum_next    = sum_reg;
        max_next    = max_reg;
        cand_next   = cand_reg;
        lt_next     = lt_reg;
        eq_next     = eq_reg;
        r50_next    = r50_reg;
        r95_next    = r95_reg;
        r99_next    = r99_reg;
        v50_next    = v50_reg;
        v95_next    = v95_reg;
        v99_next    = v99_reg;
        mean_next   = mean_reg;
        o50_next    = o50_reg;
        o95_next    = o95_reg;
        o99_next    = o99_reg;
        omax_next   = omax_reg;
        omean_next  = omean_reg;
        oheld_next  = oheld_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_addr    = wp_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && !op)
                begin
                    ram_we  = 1'b1;
                    wp_next = (wp_reg == ADDR_BITS'(WINDOW_DEPTH - 1)) ? '0
                              : wp_reg + ADDR_BITS'(1);
                    if (fill_reg != CNT_BITS'(WINDOW_DEPTH))
                        fill_next = fill_reg + CNT_BITS'(1);
                end
                else if (accept && op)
                begin
                    if (fill_reg == '0)
                    begin
                        o50_next   = '0;
                        o95_next   = '0;
                        o99_next   = '0;
                        omax_next  = '0;
                        omean_next = '0;
                        oheld_next = '0;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        n_next     = fill_reg;
                        r50_next   = rank_of(fill_reg, PCT_50);
                        r95_next   = rank_of(fill_reg, PCT_95);
                        r99_next   = rank_of(fill_reg, PCT_99);
                        idx_next   = '0;
                        rcv_next   = '0;
                        sum_next   = '0;
                        max_next   = '0;
                        state_next = S_SUM;
                    end
                end
            end
            S_SUM:
            begin
                if (idx_reg != n_reg)
                begin
                    ram_re   = 1'b1;
                    ram_addr = idx_reg[ADDR_BITS-1:0];
                    idx_next = idx_reg + CNT_BITS'(1);
                    vld_next = 1'b1;
                end
                if (vld_reg)
                begin
                    sum_next = sum_reg + SUM_BITS'(ram_rdata);
                    if (ram_rdata > max_reg)
                        max_next = ram_rdata;
                    rcv_next = rcv_reg + CNT_BITS'(1);
                    if (rcv_reg == n_reg - CNT_BITS'(1))
                    begin
                        dstart_next = 1'b1;
                        state_next  = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    mean_next  = div_quo;
                    cidx_next  = '0;
                    state_next = S_CAND;
                end
            end
            S_CAND:
            begin
                ram_re     = 1'b1;
                ram_addr   = cidx_reg[ADDR_BITS-1:0];
                idx_next   = '0;
                rcv_next   = '0;
                lt_next    = '0;
                eq_next    = '0;
                first_next = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (first_reg)
                    cand_next = ram_rdata;
                if (idx_reg != n_reg)
                begin
                    ram_re   = 1'b1;
                    ram_addr = idx_reg[ADDR_BITS-1:0];
                    idx_next = idx_reg + CNT_BITS'(1);
                    vld_next = 1'b1;
                end
                if (vld_reg)
                begin
                    lt_next  = lt_f;
                    eq_next  = eq_f;
                    rcv_next = rcv_reg + CNT_BITS'(1);
                    if (rcv_reg == n_reg - CNT_BITS'(1))
                    begin
                        if (lt_f <= r50_reg && {1'b0, r50_reg} < hi_f)
                            v50_next = cand_reg;
                        if (lt_f <= r95_reg && {1'b0, r95_reg} < hi_f)
                            v95_next = cand_reg;
                        if (lt_f <= r99_reg && {1'b0, r99_reg} < hi_f)
                            v99_next = cand_reg;
                        cidx_next  = cidx_reg + CNT_BITS'(1);
                        state_next = (cidx_reg == n_reg - CNT_BITS'(1)) ? S_DONE : S_CAND;
                    end
                end
            end
            S_DONE:
            begin
                o50_next   = LAT_BITS'(v50_reg);
                o95_next   = LAT_BITS'(v95_reg);
                o99_next   = LAT_BITS'(v99_reg);
                omax_next  = LAT_BITS'(max_reg);
                omean_next = LAT_BITS'(mean_reg);
                oheld_next = HELD_BITS'(n_reg);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            wp_reg     <= '0;
            fill_reg   <= '0;
            vld_reg    <= 1'b0;
            first_reg  <= 1'b0;
            done_reg   <= 1'b0;
            dstart_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            wp_reg     <= wp_next;
            fill_reg   <= fill_next;
            vld_reg    <= vld_next;
            first_reg  <= first_next;
            done_reg   <= done_next;
            dstart_reg <= dstart_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        idx_reg   <= idx_next;
        rcv_reg   <= rcv_next;
        cidx_reg  <= cidx_next;
        sum_reg   <= sum_next;
        max_reg   <= max_next;
        cand_reg  <= cand_next;
        lt_reg    <= lt_next;
        eq_reg    <= eq_next;
        r50_reg   <= r50_next;
        r95_reg   <= r95_next;
        r99_reg   <= r99_next;
        v50_reg   <= v50_next;
        v95_reg   <= v95_next;
        v99_reg   <= v99_next;
        mean_reg  <= mean_next;
        o50_reg   <= o50_next;
        o95_reg   <= o95_next;
        o99_reg   <= o99_next;
        omax_reg  <= omax_next;
        omean_reg <= omean_next;
        oheld_reg <= oheld_next;
    end

    assign done           = done_reg;
    assign median_latency = o50_reg;
    assign p95_latency    = o95_reg;
    assign p99_latency    = o99_reg;
    assign max_latency    = omax_reg;
    assign mean_latency   = omean_reg;
    assign samples_held   = oheld_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_BITS'(WINDOW_DEPTH))
        else $error("fill count beyond window depth");

    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg == S_IDLE)
        else $error("sample write outside idle");

    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done) |-> $past(state_reg == S_DONE || (accept && op)))
        else $error("result strobe without query");

    a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside mean phase");
endmodule
`default_nettype wire

/* sim/tb.sv */
// Testbench for windowed_latency_percentiles_top: record/query transfers against a
// sorted-window predictor held in a small scoreboard class. Depends on wlp_pkg and the top.
`default_nettype none
module tb;
    import wlp_pkg::*;

    localparam int STALL_LIMIT = 80000;

    typedef struct packed {
        logic [LAT_BITS-1:0]  med;
        logic [LAT_BITS-1:0]  p95;
        logic [LAT_BITS-1:0]  p99;
        logic [LAT_BITS-1:0]  mx;
        logic [LAT_BITS-1:0]  mean;
        logic [HELD_BITS-1:0] held;
    } stats_t;

    class window_scoreboard;
        logic [SAMPLE_BITS-1:0] ring[WINDOW_DEPTH];
        int unsigned            wpos;
        int unsigned            fill;
        stats_t                 pending_stats[$];
        int unsigned            errors;

        function new();
            wpos = 0;
            fill = 0;
            errors = 0;
        endfunction

        function void note_transfer(logic kind, logic [LAT_BITS-1:0] lat);
            longint unsigned smax;
            longint unsigned v;
            longint unsigned sum;
            logic [SAMPLE_BITS-1:0] sorted[$];
            stats_t s;
            smax = (64'd1 << SAMPLE_BITS) - 1;
            if (kind == 1'b0) begin
                v = lat;
                if (v > smax)
                    v = smax;
                ring[wpos] = v[SAMPLE_BITS-1:0];
                wpos = (wpos + 1) % WINDOW_DEPTH;
                if (fill < WINDOW_DEPTH)
                    fill++;
                return;
            end
            s = '{default: '0};
            if (fill != 0) begin
                sum = 0;
                for (int i = 0; i < fill; i++) begin
                    sorted.push_back(ring[i]);
                    sum += ring[i];
                end
                sorted.sort();
                s.med  = LAT_BITS'(sorted[(fill * 50) / 100]);
                s.p95  = LAT_BITS'(sorted[(fill * 95) / 100]);
                s.p99  = LAT_BITS'(sorted[(fill * 99) / 100]);
                s.mx   = LAT_BITS'(sorted[fill - 1]);
                s.mean = LAT_BITS'(sum / fill);
                s.held = HELD_BITS'(fill);
            end
            pending_stats.push_back(s);
        endfunction

        function void check_result(stats_t got);
            stats_t e;
            if (pending_stats.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: med=%0d held=%0d", got.med, got.held);
                return;
            end
            e = pending_stats.pop_front();
            if (got != e) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: exp med=%0d p95=%0d p99=%0d max=%0d mean=%0d n=%0d,",
                              " got med=%0d p95=%0d p99=%0d max=%0d mean=%0d n=%0d"},
                             e.med, e.p95, e.p99, e.mx, e.mean, e.held,
                             got.med, got.p95, got.p99, got.mx, got.mean, got.held);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 op;
    logic [LAT_BITS-1:0]  latency_sample;
    logic                 done;
    logic [LAT_BITS-1:0]  median_latency;
    logic [LAT_BITS-1:0]  p95_latency;
    logic [LAT_BITS-1:0]  p99_latency;
    logic [LAT_BITS-1:0]  max_latency;
    logic [LAT_BITS-1:0]  mean_latency;
    logic [HELD_BITS-1:0] samples_held;

    window_scoreboard sb;
    int unsigned      idle_pct;
    int unsigned      stall_cycles;
    logic             accepted;

    windowed_latency_percentiles_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .op(op), .latency_sample(latency_sample), .done(done),
        .median_latency(median_latency), .p95_latency(p95_latency),
        .p99_latency(p99_latency), .max_latency(max_latency),
        .mean_latency(mean_latency), .samples_held(samples_held)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // transfer one item, then idle at random
    task automatic send(logic kind, logic [LAT_BITS-1:0] lat);
        int unsigned gap;
        start          <= 1'b1;
        op             <= kind;
        latency_sample <= lat;
        do
            @(posedge clk);
        while (busy);
        sb.note_transfer(kind, lat);
        if ($urandom_range(99) < idle_pct) begin
            gap = $urandom_range(4, 1);
            start          <= 1'b0;
            op             <= 1'($urandom);
            latency_sample <= LAT_BITS'($urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending_stats.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [LAT_BITS-1:0] rand_sample();
        case ($urandom_range(5))
            0: return '1;
            1: return LAT_BITS'($urandom_range(255));
            2: return '0;
            default: return LAT_BITS'($urandom);
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result('{median_latency, p95_latency, p99_latency,
                              max_latency, mean_latency, samples_held});
    end

    always @(posedge clk)
    begin
        accepted = (start && !busy) || done;
        if (!rst_n || accepted)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        sb             = new();
        idle_pct       = 0;
        rst_n          = 1'b0;
        start          = 1'b0;
        op             = 1'b0;
        latency_sample = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(1'b1, '1);
        send(1'b0, '0);
        send(1'b1, '0);
        send(1'b0, '1);
        send(1'b1, '0);
        send(1'b0, 24'hAAAAAA);
        send(1'b0, 24'h555555);
        send(1'b0, 24'h000001);
        send(1'b0, 24'h800000);
        send(1'b1, '0);
        for (int i = 0; i < 10; i++)
            send(1'b0, LAT_BITS'($urandom));
        send(1'b1, '1);
        drain();

        for (int i = 0; i < 1700; i++) begin
            if (i < 570)
                idle_pct = 17;
            else if (i < 1140)
                idle_pct = 51;
            else
                idle_pct = 0;
            if (i == 850)
                drain();
            if ($urandom_range(49) == 0)
                send(1'b1, LAT_BITS'($urandom));
            else
                send(1'b0, rand_sample());
        end
        send(1'b1, '0);
        drain();
        repeat (20) @(posedge clk);

        if (sb.errors == 0 && sb.pending_stats.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire
